FILE: rtl/core/pffl_pkg.sv
// Shared types and constants for the page frame free list allocator.
`default_nettype none

package pffl_pkg;

    localparam int unsigned CFG_W      = 13;
    localparam int unsigned CNT_W      = 13;
    localparam int unsigned APB_ADDR_W = 4;

    localparam logic [CNT_W-1:0] COUNT_MAX = 13'h1FFF;

    // Register indexes on the configuration port (byte address / 4).
    localparam logic [1:0] REG_FRAME_COUNT    = 2'd0;
    localparam logic [1:0] REG_RESERVED_FIRST = 2'd1;
    localparam logic [1:0] REG_RESERVED_LAST  = 2'd2;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RST    = 13'd4096;
    localparam logic [CFG_W-1:0] RESERVED_FIRST_RST = 13'd160;
    localparam logic [CFG_W-1:0] RESERVED_LAST_RST  = 13'd160;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_INIT  = 2'd2;

    localparam logic [1:0] MARK_FREE     = 2'd1;
    localparam logic [1:0] MARK_USED     = 2'd2;
    localparam logic [1:0] MARK_RESERVED = 2'd3;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_EMPTY   = 2'd1;
    localparam logic [1:0] ST_CORRUPT = 2'd2;
    localparam logic [1:0] ST_BADADDR = 2'd3;

    // Lower bound of frames that may ever be on the list.
    localparam int unsigned LOW_RESERVED = 2;

    typedef struct packed {
        logic [CFG_W-1:0] frame_count;
        logic [CFG_W-1:0] reserved_first;
        logic [CFG_W-1:0] reserved_last;
    } pffl_cfg_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] phys_address;
    } pffl_req_t;

    typedef struct packed {
        logic [1:0]       status;
        logic [31:0]      frame_address;
        logic [CNT_W-1:0] frames_free;
    } pffl_rsp_t;

endpackage

`default_nettype wire

FILE: rtl/core/pffl_cfg.sv
// APB configuration registers of the page frame free list allocator.
`default_nettype none

module pffl_cfg (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [pffl_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready,
    output pffl_pkg::pffl_cfg_t                    cfg
);
    import pffl_pkg::*;

    logic [CFG_W-1:0] frame_count_reg;
    logic [CFG_W-1:0] reserved_first_reg;
    logic [CFG_W-1:0] reserved_last_reg;
    logic             wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg    <= FRAME_COUNT_RST;
            reserved_first_reg <= RESERVED_FIRST_RST;
            reserved_last_reg  <= RESERVED_LAST_RST;
        end
        else if (wr_en)
        begin
            case (paddr[3:2])
                REG_FRAME_COUNT:    frame_count_reg    <= pwdata[CFG_W-1:0];
                REG_RESERVED_FIRST: reserved_first_reg <= pwdata[CFG_W-1:0];
                REG_RESERVED_LAST:  reserved_last_reg  <= pwdata[CFG_W-1:0];
                default:            ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_FRAME_COUNT:    prdata = 32'(frame_count_reg);
            REG_RESERVED_FIRST: prdata = 32'(reserved_first_reg);
            REG_RESERVED_LAST:  prdata = 32'(reserved_last_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg.frame_count    = frame_count_reg;
    assign cfg.reserved_first = reserved_first_reg;
    assign cfg.reserved_last  = reserved_last_reg;

endmodule

`default_nettype wire

FILE: rtl/core/page_frame_free_list_core.sv
// Top level of the page frame free list allocator: control and frame memory.
// An item is taken when start is high and busy is low; its result appears on rsp for
// exactly one cycle with done high and cannot be held off. Allocate on a nonempty list
// reads the head frame's entry through the registered memory read port and, if it is
// marked free, writes it back marked used before its result is registered. Allocate on an
// empty list, free and the unused action need no read and answer in the cycle after they
// are taken. Rebuild sweeps the frame memory from the top frame down, one entry per
// cycle, so busy stays high for the whole sweep, and the result is registered as the
// bottom frame is written. After reset the list is empty and the memory contents are
// unknown until a rebuild or a free writes them. busy is low again in the cycle the
// result is shown, so the next item may follow at once.
`default_nettype none

module page_frame_free_list_core #(
    parameter int unsigned MAX_FRAMES = 4096,
    parameter int unsigned PAGE_SHIFT = 12
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire pffl_pkg::pffl_req_t               req,
    output logic                                   done,
    output pffl_pkg::pffl_rsp_t                    rsp,
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [pffl_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready
);
    import pffl_pkg::*;

    localparam int unsigned FW = $clog2(MAX_FRAMES);
    // Width for comparing frame numbers against 13-bit registers and MAX_FRAMES.
    localparam int unsigned CW = (FW + 1 > CFG_W) ? FW + 1 : CFG_W;
    // Width of the frame number taken from a physical address.
    localparam int unsigned AW = 32 - PAGE_SHIFT;
    localparam int unsigned DW = (AW > CW) ? AW : CW;
    // Memory entry: {mark, end of list, next frame}.
    localparam int unsigned EW = FW + 3;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_ALLOC = 2'd1;
    localparam logic [1:0] S_INIT  = 2'd2;

    pffl_cfg_t cfg;

    pffl_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    logic [EW-1:0] mem [MAX_FRAMES];
    logic [EW-1:0] mem_rdata;
    logic          mem_re;
    logic          mem_we;
    logic [FW-1:0] mem_waddr;
    logic [EW-1:0] mem_wdata;

    logic [1:0]       state_reg, state_next;
    logic [FW-1:0]    head_reg, head_next;
    logic             head_valid_reg, head_valid_next;
    logic [CNT_W-1:0] free_total_reg, free_total_next;
    logic [FW-1:0]    scan_reg, scan_next;
    logic [FW-1:0]    tail_reg, tail_next;
    logic             tail_valid_reg, tail_valid_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             done_reg, done_next;
    pffl_rsp_t        rsp_reg, rsp_next;

    logic [CW-1:0]    frames_present;
    logic [CW-1:0]    frame_count_ext;
    logic [CW-1:0]    scan_ext;
    logic             scan_usable;
    logic [CNT_W-1:0] count_inc;
    logic [DW-1:0]    free_frame;
    logic [DW-1:0]    present_wide;
    logic             free_ok;
    logic [FW-1:0]    free_idx;
    logic [1:0]       rd_mark;
    logic             rd_end;
    logic [FW-1:0]    rd_link;
    logic [63:0]      addr_wide;

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            mem_rdata <= mem[head_reg];
        end
    end

    assign frame_count_ext = CW'(cfg.frame_count);
    assign frames_present  = (frame_count_ext > CW'(MAX_FRAMES)) ? CW'(MAX_FRAMES)
                                                                  : frame_count_ext;

    assign scan_ext    = CW'(scan_reg);
    assign scan_usable = (scan_ext >= CW'(LOW_RESERVED)) && (scan_ext < frames_present)
                         && !((scan_ext >= CW'(cfg.reserved_first))
                              && (scan_ext < CW'(cfg.reserved_last)));
    assign count_inc   = (scan_usable && count_reg != COUNT_MAX) ? count_reg + 1'b1
                                                                 : count_reg;

    assign free_frame   = DW'(req.phys_address[31:PAGE_SHIFT]);
    assign present_wide = DW'(frames_present);
    assign free_ok      = (free_frame >= DW'(LOW_RESERVED)) && (free_frame < present_wide);
    assign free_idx     = free_frame[FW-1:0];

    assign rd_mark = mem_rdata[EW-1:EW-2];
    assign rd_end  = mem_rdata[FW];
    assign rd_link = mem_rdata[FW-1:0];

    assign addr_wide = 64'(head_reg) << PAGE_SHIFT;

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        head_valid_next = head_valid_reg;
        free_total_next = free_total_reg;
        scan_next       = scan_reg;
        tail_next       = tail_reg;
        tail_valid_next = tail_valid_reg;
        count_next      = count_reg;
        done_next       = 1'b0;
        rsp_next        = rsp_reg;
        mem_re          = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = head_reg;
        mem_wdata       = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    case (req.action)
                        ACT_ALLOC:
                        begin
                            if (!head_valid_reg)
                            begin
                                done_next = 1'b1;
                                rsp_next  = '{ST_EMPTY, 32'd0, free_total_reg};
                            end
                            else
                            begin
                                mem_re     = 1'b1;
                                state_next = S_ALLOC;
                            end
                        end
                        ACT_FREE:
                        begin
                            done_next = 1'b1;
                            if (free_ok)
                            begin
                                mem_we    = 1'b1;
                                mem_waddr = free_idx;
                                mem_wdata = {MARK_FREE, !head_valid_reg,
                                             head_valid_reg ? head_reg : FW'(0)};
                                head_next       = free_idx;
                                head_valid_next = 1'b1;
                                free_total_next = (free_total_reg == COUNT_MAX)
                                                  ? free_total_reg : free_total_reg + 1'b1;
                                rsp_next = '{ST_OK, 32'd0, free_total_next};
                            end
                            else
                            begin
                                rsp_next = '{ST_BADADDR, 32'd0, free_total_reg};
                            end
                        end
                        ACT_INIT:
                        begin
                            state_next      = S_INIT;
                            scan_next       = FW'(MAX_FRAMES - 1);
                            tail_valid_next = 1'b0;
                            count_next      = '0;
                        end
                        default:
                        begin
                            done_next = 1'b1;
                            rsp_next  = '{ST_OK, 32'd0, free_total_reg};
                        end
                    endcase
                end
            end
            S_ALLOC:
            begin
                state_next = S_IDLE;
                done_next  = 1'b1;
                if (rd_mark != MARK_FREE)
                begin
                    rsp_next = '{ST_CORRUPT, 32'd0, free_total_reg};
                end
                else
                begin
                    mem_we          = 1'b1;
                    mem_waddr       = head_reg;
                    mem_wdata       = {MARK_USED, 1'b1, FW'(0)};
                    head_next       = rd_end ? FW'(0) : rd_link;
                    head_valid_next = !rd_end;
                    free_total_next = (free_total_reg == '0) ? free_total_reg
                                                             : free_total_reg - 1'b1;
                    rsp_next = '{ST_OK, addr_wide[31:0], free_total_next};
                end
            end
            S_INIT:
            begin
                // The sweep runs downward so each usable frame links to the next usable frame above it.
                mem_we    = 1'b1;
                mem_waddr = scan_reg;
                if (scan_usable)
                begin
                    mem_wdata       = {MARK_FREE, !tail_valid_reg,
                                       tail_valid_reg ? tail_reg : FW'(0)};
                    tail_next       = scan_reg;
                    tail_valid_next = 1'b1;
                end
                else
                begin
                    mem_wdata = {MARK_RESERVED, 1'b1, FW'(0)};
                end
                count_next = count_inc;
                if (scan_reg == '0)
                begin
                    state_next      = S_IDLE;
                    head_next       = scan_usable ? scan_reg : tail_reg;
                    head_valid_next = scan_usable || tail_valid_reg;
                    free_total_next = count_inc;
                    done_next       = 1'b1;
                    rsp_next        = '{ST_OK, 32'd0, count_inc};
                end
                else
                begin
                    scan_next = scan_reg - 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            head_reg       <= '0;
            head_valid_reg <= 1'b0;
            free_total_reg <= '0;
            scan_reg       <= '0;
            tail_reg       <= '0;
            tail_valid_reg <= 1'b0;
            count_reg      <= '0;
            done_reg       <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            head_reg       <= head_next;
            head_valid_reg <= head_valid_next;
            free_total_reg <= free_total_next;
            scan_reg       <= scan_next;
            tail_reg       <= tail_next;
            tail_valid_reg <= tail_valid_next;
            count_reg      <= count_next;
            done_reg       <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

`default_nettype wire

FILE: sim/page_frame_free_list_core_tb.sv
// Self-checking testbench for the page frame free list core: directed cases, then random traffic.
module page_frame_free_list_core_tb;

    timeunit 1ns;
    timeprecision 1ps;

    import pffl_pkg::*;

    localparam int unsigned TB_MAX_FRAMES = 4096;
    localparam int unsigned TB_PAGE_SHIFT = 12;
    localparam logic [CNT_W-1:0] TB_END_LINK = 13'd4096;

    localparam logic [1:0] ACT_NONE     = 2'd3;
    localparam logic [1:0] REG_UNMAPPED = 2'd3;

    logic                  clk;
    logic                  rst_n;
    logic                  start;
    logic                  busy;
    pffl_req_t             req;
    logic                  done;
    pffl_rsp_t             rsp;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [31:0]           pwdata;
    logic [31:0]           prdata;
    logic                  pready;

    // Shadow copy of the allocator: configuration, list head, count and per-frame memory.
    logic [CFG_W-1:0] cfg_frames;
    logic [CFG_W-1:0] cfg_rsv_first;
    logic [CFG_W-1:0] cfg_rsv_last;
    logic             sh_head_ok;
    logic [CNT_W-1:0] sh_head;
    logic [CNT_W-1:0] sh_free;
    logic [CNT_W-1:0] sh_link [TB_MAX_FRAMES];
    logic [1:0]       sh_mark [TB_MAX_FRAMES];

    pffl_rsp_t   awaited [$];
    int unsigned held_frames [$];
    int          sender_idle_pct;
    int          errors;

    page_frame_free_list_core #(
        .MAX_FRAMES (TB_MAX_FRAMES),
        .PAGE_SHIFT (TB_PAGE_SHIFT)
    ) u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .req     (req),
        .done    (done),
        .rsp     (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // The slowest correct run is dominated by the rebuild sweeps.
    initial
    begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic int unsigned present_frames();
        begin
            return (cfg_frames > TB_MAX_FRAMES) ? TB_MAX_FRAMES : int'(cfg_frames);
        end
    endfunction

    task automatic rebuild_frame_list();
        int unsigned n;
        int unsigned tail;
        int unsigned cnt;
        logic        usable;
        begin
            n = present_frames();
            tail = 32'(TB_END_LINK);
            cnt = 0;
            sh_head_ok = 1'b0;
            sh_head = '0;
            for (int unsigned f = 0; f < TB_MAX_FRAMES; f++)
            begin
                usable = (f >= LOW_RESERVED) && (f < n) &&
                         !((f >= cfg_rsv_first) && (f < cfg_rsv_last));
                sh_link[f] = TB_END_LINK;
                if (!usable)
                begin
                    sh_mark[f] = MARK_RESERVED;
                end
                else
                begin
                    sh_mark[f] = MARK_FREE;
                    if (tail == TB_END_LINK)
                    begin
                        sh_head = f[CNT_W-1:0];
                        sh_head_ok = 1'b1;
                    end
                    else
                    begin
                        sh_link[tail] = f[CNT_W-1:0];
                    end
                    tail = f;
                    cnt++;
                end
            end
            sh_free = (cnt > COUNT_MAX) ? COUNT_MAX : cnt[CNT_W-1:0];
        end
    endtask

    // Applies one item to the shadow list and returns the answer the core must give.
    task automatic step_frame_list(input pffl_req_t item, output pffl_rsp_t answer);
        int unsigned f;
        logic [CNT_W-1:0] nx;
        begin
            answer.status = ST_OK;
            answer.frame_address = '0;
            case (item.action)
                ACT_ALLOC:
                begin
                    if (!sh_head_ok)
                    begin
                        answer.status = ST_EMPTY;
                    end
                    else if (sh_mark[sh_head] != MARK_FREE)
                    begin
                        answer.status = ST_CORRUPT;
                    end
                    else
                    begin
                        f = 32'(sh_head);
                        nx = sh_link[f];
                        if (nx >= TB_MAX_FRAMES)
                        begin
                            sh_head_ok = 1'b0;
                            sh_head = '0;
                        end
                        else
                        begin
                            sh_head = nx;
                        end
                        if (sh_free > 0)
                            sh_free = sh_free - 1'b1;
                        sh_link[f] = TB_END_LINK;
                        sh_mark[f] = MARK_USED;
                        answer.frame_address = f << TB_PAGE_SHIFT;
                        held_frames.push_back(f);
                    end
                end
                ACT_FREE:
                begin
                    f = item.phys_address >> TB_PAGE_SHIFT;
                    if (f >= LOW_RESERVED && f < present_frames())
                    begin
                        sh_link[f] = sh_head_ok ? sh_head : TB_END_LINK;
                        sh_head = f[CNT_W-1:0];
                        sh_head_ok = 1'b1;
                        sh_mark[f] = MARK_FREE;
                        if (sh_free < COUNT_MAX)
                            sh_free = sh_free + 1'b1;
                    end
                    else
                    begin
                        answer.status = ST_BADADDR;
                    end
                end
                ACT_INIT:
                begin
                    rebuild_frame_list();
                    held_frames.delete();
                end
                default:
                begin
                end
            endcase
            answer.frames_free = sh_free;
        end
    endtask

    // Called at a falling edge; returns at the falling edge after the item was taken,
    // with start still high so that a following item can go out back to back.
    task automatic send_item(input logic [1:0] act, input logic [31:0] addr);
        pffl_req_t item;
        pffl_rsp_t want;
        int        gap;
        begin
            item.action = act;
            item.phys_address = addr;
            gap = 0;
            while (gap < 40 && $urandom_range(99) < sender_idle_pct)
                gap++;
            if (gap > 0)
            begin
                start <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            start <= 1'b1;
            req <= item;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            step_frame_list(item, want);
            awaited.push_back(want);
            @(negedge clk);
        end
    endtask

    task automatic send_free_frame(input int unsigned f);
        begin
            send_item(ACT_FREE, (f << TB_PAGE_SHIFT) | $urandom_range(4095));
        end
    endtask

    task automatic wait_idle();
        begin
            start <= 1'b0;
            while (awaited.size() != 0)
                @(posedge clk);
            @(negedge clk);
        end
    endtask

    // Write one register, then read it back unless it is unmapped; only the low 13 bits are kept.
    task automatic write_reg(input logic [1:0] index, input logic [CFG_W-1:0] value);
        logic [31:0] junk;
        logic [31:0] got;
        begin
            junk = $urandom;
            psel <= 1'b1;
            penable <= 1'b0;
            pwrite <= 1'b1;
            paddr <= {index, 2'b00};
            pwdata <= {junk[31:CFG_W], value};
            @(negedge clk);
            penable <= 1'b1;
            @(negedge clk);
            case (index)
                REG_FRAME_COUNT:    cfg_frames = value;
                REG_RESERVED_FIRST: cfg_rsv_first = value;
                REG_RESERVED_LAST:  cfg_rsv_last = value;
                default:
                begin
                end
            endcase
            if (index == REG_UNMAPPED)
            begin
                psel <= 1'b0;
                penable <= 1'b0;
                pwrite <= 1'b0;
            end
            else
            begin
                penable <= 1'b0;
                pwrite <= 1'b0;
                @(negedge clk);
                penable <= 1'b1;
                @(posedge clk);
                got = prdata;
                if (got !== {{(32-CFG_W){1'b0}}, value})
                begin
                    $display("%0t: register %0d read back expected %0h, got %0h",
                             $time, index, value, got);
                    errors++;
                end
                @(negedge clk);
                psel <= 1'b0;
                penable <= 1'b0;
            end
            @(negedge clk);
        end
    endtask

    task automatic set_config(input logic [CFG_W-1:0] frames, input logic [CFG_W-1:0] first,
                              input logic [CFG_W-1:0] last);
        begin
            wait_idle();
            write_reg(REG_FRAME_COUNT, frames);
            write_reg(REG_RESERVED_FIRST, first);
            write_reg(REG_RESERVED_LAST, last);
        end
    endtask

    always @(posedge clk)
    begin : check_results
        pffl_rsp_t want;
        if (rst_n && done)
        begin
            if (awaited.size() == 0)
            begin
                $display("%0t: result with no item outstanding: expected none, got %p",
                         $time, rsp);
                errors++;
            end
            else
            begin
                want = awaited.pop_front();
                if (rsp.status !== want.status)
                begin
                    $display("%0t: status expected %0d, got %0d",
                             $time, want.status, rsp.status);
                    errors++;
                end
                if (rsp.frame_address !== want.frame_address)
                begin
                    $display("%0t: frame_address expected %h, got %h",
                             $time, want.frame_address, rsp.frame_address);
                    errors++;
                end
                if (rsp.frames_free !== want.frames_free)
                begin
                    $display("%0t: frames_free expected %0d, got %0d",
                             $time, want.frames_free, rsp.frames_free);
                    errors++;
                end
            end
        end
    end

    task automatic test_reset_state();
        begin
            send_item(ACT_ALLOC, 32'h0);
            send_item(ACT_NONE, 32'hFFFF_FFFF);
        end
    endtask

    // Frames freed before any rebuild form a list of their own.
    task automatic test_free_before_rebuild();
        begin
            send_free_frame(5);
            send_item(ACT_ALLOC, 32'hFFFF_FFFF);
            send_item(ACT_ALLOC, 32'h0);
        end
    endtask

    task automatic test_bad_address();
        begin
            send_item(ACT_FREE, 32'h0000_0000);
            send_item(ACT_FREE, 32'h0000_1FFF);
            send_item(ACT_FREE, 32'hFFFF_FFFF);
            send_item(ACT_FREE, 32'h0100_0000);
            send_item(ACT_FREE, 32'h00FF_FFFF);
        end
    endtask

    task automatic test_rebuild();
        begin
            send_item(ACT_INIT, $urandom);
            send_item(ACT_ALLOC, 32'h0);
            send_item(ACT_ALLOC, 32'h0);
        end
    endtask

    // A frame freed twice links to itself, so the second pop finds it marked used.
    task automatic test_double_free();
        begin
            send_free_frame(3);
            send_free_frame(3);
            send_item(ACT_ALLOC, 32'h0);
            send_item(ACT_ALLOC, 32'h0);
        end
    endtask

    task automatic test_reserved_range();
        begin
            set_config(13'd8, 13'd3, 13'd6);
            send_item(ACT_INIT, 32'h0);
            repeat (4) send_item(ACT_ALLOC, $urandom);
        end
    endtask

    task automatic test_frame_count_limits();
        begin
            set_config(13'h1FFF, 13'h1FFF, 13'h1FFF);
            send_item(ACT_INIT, 32'h0);
            send_free_frame(4095);
            send_free_frame(4096);
            set_config(13'd4096, 13'd0, 13'h1FFF);
            send_item(ACT_INIT, 32'h0);
            send_item(ACT_ALLOC, 32'h0);
            set_config(13'd2, 13'd0, 13'd0);
            send_item(ACT_INIT, 32'h0);
            send_item(ACT_ALLOC, 32'h0);
            send_free_frame(2);
            set_config(13'd3, 13'd0, 13'd0);
            wait_idle();
            write_reg(REG_UNMAPPED, 13'h1FFF);
            send_item(ACT_INIT, 32'h0);
            send_item(ACT_ALLOC, 32'h0);
            send_item(ACT_ALLOC, 32'h0);
        end
    endtask

    // Enough repeated frees to drive the free count into its upper limit.
    task automatic test_count_saturation();
        begin
            set_config(13'd4096, 13'd160, 13'd160);
            send_item(ACT_INIT, 32'h0);
            repeat (4110) send_free_frame($urandom_range(4095, 2));
            repeat (4) send_item(ACT_ALLOC, 32'h0);
            send_item(ACT_INIT, 32'h0);
        end
    endtask

    task automatic run_traffic(input int count);
        int unsigned n;
        int unsigned f;
        int unsigned pick;
        int          r;
        begin
            send_item(ACT_INIT, $urandom);
            repeat (count)
            begin
                n = present_frames();
                r = $urandom_range(99);
                if (r < 40)
                begin
                    send_item(ACT_ALLOC, $urandom);
                end
                else if (r < 62 && held_frames.size() != 0)
                begin
                    pick = $urandom_range(held_frames.size() - 1);
                    f = held_frames[pick];
                    held_frames.delete(pick);
                    send_free_frame(f);
                end
                else if (r < 72)
                begin
                    send_free_frame($urandom_range(n - 1));
                end
                else if (r < 78)
                begin
                    send_item(ACT_FREE, $urandom);
                end
                else if (r < 84)
                begin
                    case ($urandom_range(5))
                        0: f = 0;
                        1: f = 1;
                        2: f = n - 1;
                        3: f = n;
                        4: f = TB_MAX_FRAMES - 1;
                        default: f = TB_MAX_FRAMES;
                    endcase
                    send_free_frame(f);
                end
                else if (r < 86)
                begin
                    send_item(ACT_INIT, $urandom);
                end
                else if (r < 90)
                begin
                    send_item(ACT_NONE, $urandom);
                end
                else
                begin
                    send_item(ACT_ALLOC, $urandom);
                end
            end
        end
    endtask

    task automatic test_random_traffic();
        int          idle_pct [4];
        logic [CFG_W-1:0] fc;
        begin
            idle_pct = '{0, 77, 0, 38};
            for (int p = 0; p < 4; p++)
            begin
                sender_idle_pct = idle_pct[p];
                case (p)
                    0: set_config(13'd4096, 13'd160, 13'd160);
                    1: set_config(13'd16, 13'd4, 13'd9);
                    2: set_config(13'd3, 13'd0, 13'd0);
                    default: set_config(13'd64, 13'd40, 13'd20);
                endcase
                run_traffic(220);
                if ($urandom_range(3) == 0)
                    fc = CFG_W'($urandom_range(4096, 2));
                else
                    fc = CFG_W'($urandom_range(200, 2));
                set_config(fc, CFG_W'($urandom_range(32'(fc) + 4)),
                           CFG_W'($urandom_range(32'(fc) + 4)));
                run_traffic(220);
            end
            sender_idle_pct = 0;
        end
    endtask

    initial
    begin
        rst_n = 1'b0;
        start = 1'b0;
        req = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        errors = 0;
        sender_idle_pct = 0;
        cfg_frames = FRAME_COUNT_RST;
        cfg_rsv_first = RESERVED_FIRST_RST;
        cfg_rsv_last = RESERVED_LAST_RST;
        sh_head_ok = 1'b0;
        sh_head = '0;
        sh_free = '0;
        for (int i = 0; i < TB_MAX_FRAMES; i++)
        begin
            sh_link[i] = '0;
            sh_mark[i] = '0;
        end
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        test_reset_state();
        test_free_before_rebuild();
        test_bad_address();
        test_rebuild();
        test_double_free();
        test_reserved_range();
        test_frame_count_limits();
        test_count_saturation();
        test_random_traffic();

        wait_idle();
        repeat (8) @(posedge clk);
        if (errors == 0 && awaited.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
